// ===== src/ubd_pkg.sv =====
// Shared widths, transaction types and constant tables for the UART baud divisor calculator.
// No dependencies; every other file in src imports this package.
`default_nettype none

package ubd_pkg;

  localparam int unsigned CLK_W         = 32;
  localparam int unsigned BAUD_W        = 24;
  localparam int unsigned DIV_W         = 16;
  localparam int unsigned FMOD_W        = 4;
  localparam int unsigned SMOD_W        = 8;
  localparam int unsigned QUO_W         = CLK_W;
  localparam int unsigned QLO_W         = DIV_W + FMOD_W;
  localparam int unsigned THR_W         = 14;
  localparam int unsigned LHS_W         = BAUD_W + THR_W;
  localparam int unsigned TABLE_ENTRIES = 36;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  localparam logic [THR_W-1:0] FRAC_SCALE = THR_W'(10000);

  typedef struct packed {
    logic [BAUD_W-1:0] rem;
    logic [QUO_W-1:0]  num;
    logic [BAUD_W-1:0] baud;
  } div_t;

  typedef struct packed {
    logic [LHS_W-1:0]  lhs;
    logic [BAUD_W-1:0] baud;
    logic [IDX_W-1:0]  idx;
    logic [QLO_W-1:0]  quo_lo;
    logic              err;
  } srch_t;

  typedef struct packed {
    logic [DIV_W-1:0]  divisor;
    logic [FMOD_W-1:0] first_mod;
    logic [SMOD_W-1:0] second_mod;
    logic              status;
  } res_t;

  // thresholds in units of 1/10000
  function automatic logic [THR_W-1:0] thr_at(input logic [IDX_W-1:0] idx);
    logic [THR_W-1:0] t;
    case (idx)
      6'd0:  t = THR_W'(0);
      6'd1:  t = THR_W'(529);
      6'd2:  t = THR_W'(715);
      6'd3:  t = THR_W'(835);
      6'd4:  t = THR_W'(1001);
      6'd5:  t = THR_W'(1252);
      6'd6:  t = THR_W'(1430);
      6'd7:  t = THR_W'(1670);
      6'd8:  t = THR_W'(2147);
      6'd9:  t = THR_W'(2224);
      6'd10: t = THR_W'(2503);
      6'd11: t = THR_W'(3000);
      6'd12: t = THR_W'(3335);
      6'd13: t = THR_W'(3575);
      6'd14: t = THR_W'(3753);
      6'd15: t = THR_W'(4003);
      6'd16: t = THR_W'(4286);
      6'd17: t = THR_W'(4378);
      6'd18: t = THR_W'(5002);
      6'd19: t = THR_W'(5715);
      6'd20: t = THR_W'(6003);
      6'd21: t = THR_W'(6254);
      6'd22: t = THR_W'(6432);
      6'd23: t = THR_W'(6667);
      6'd24: t = THR_W'(7001);
      6'd25: t = THR_W'(7147);
      6'd26: t = THR_W'(7503);
      6'd27: t = THR_W'(7861);
      6'd28: t = THR_W'(8004);
      6'd29: t = THR_W'(8333);
      6'd30: t = THR_W'(8464);
      6'd31: t = THR_W'(8572);
      6'd32: t = THR_W'(8751);
      6'd33: t = THR_W'(9004);
      6'd34: t = THR_W'(9170);
      6'd35: t = THR_W'(9288);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [SMOD_W-1:0] pat_at(input logic [IDX_W-1:0] idx);
    logic [SMOD_W-1:0] p;
    case (idx)
      6'd0:  p = 8'h00;
      6'd1:  p = 8'h01;
      6'd2:  p = 8'h02;
      6'd3:  p = 8'h04;
      6'd4:  p = 8'h08;
      6'd5:  p = 8'h10;
      6'd6:  p = 8'h20;
      6'd7:  p = 8'h11;
      6'd8:  p = 8'h21;
      6'd9:  p = 8'h22;
      6'd10: p = 8'h44;
      6'd11: p = 8'h25;
      6'd12: p = 8'h49;
      6'd13: p = 8'h4A;
      6'd14: p = 8'h52;
      6'd15: p = 8'h92;
      6'd16: p = 8'h53;
      6'd17: p = 8'h55;
      6'd18: p = 8'hAA;
      6'd19: p = 8'h6B;
      6'd20: p = 8'hAD;
      6'd21: p = 8'hB5;
      6'd22: p = 8'hB6;
      6'd23: p = 8'hD6;
      6'd24: p = 8'hB7;
      6'd25: p = 8'hBB;
      6'd26: p = 8'hDD;
      6'd27: p = 8'hED;
      6'd28: p = 8'hEE;
      6'd29: p = 8'hBF;
      6'd30: p = 8'hDF;
      6'd31: p = 8'hEF;
      6'd32: p = 8'hF7;
      6'd33: p = 8'hFB;
      6'd34: p = 8'hFD;
      6'd35: p = 8'hFE;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== src/ubd_if.sv =====
// Valid/ready channel interfaces for request and result transactions.
// Depends on ubd_pkg for field widths.
`default_nettype none

interface ubd_in_if
  import ubd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CLK_W-1:0]  clock_hz;
  logic [BAUD_W-1:0] baud_rate;

  modport source (output valid, output clock_hz, output baud_rate, input ready);
  modport sink   (input valid, input clock_hz, input baud_rate, output ready);
endinterface

interface ubd_out_if
  import ubd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DIV_W-1:0]  divisor;
  logic [FMOD_W-1:0] first_mod;
  logic [SMOD_W-1:0] second_mod;
  logic              status;

  modport source (output valid, output divisor, output first_mod, output second_mod,
                  output status, input ready);
  modport sink   (input valid, input divisor, input first_mod, input second_mod,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== src/ubd_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of clock_hz / baud_rate.
// Depends on ubd_pkg (div_t).
`default_nettype none

module ubd_div_cell
  import ubd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic v_i,
  input  wire div_t d_i,
  output      logic v_o,
  output      div_t d_o
);

  logic            v_r;
  div_t            d_r;
  div_t            d_nxt;
  logic [BAUD_W:0] trial;
  logic            ge;

  always_comb begin
    trial = {d_i.rem, d_i.num[QUO_W-1]};
    ge    = trial >= {1'b0, d_i.baud};
    d_nxt = d_i;
    d_nxt.rem = ge ? BAUD_W'(trial - {1'b0, d_i.baud}) : trial[BAUD_W-1:0];
    d_nxt.num = {d_i.num[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

`default_nettype wire

// ===== src/ubd_srch_cell.sv =====
// One binary-search cell over the threshold table: decides one index bit by an exact
// compare of remainder*10000 against threshold*baud. Depends on ubd_pkg.
`default_nettype none

module ubd_srch_cell
  import ubd_pkg::*;
#(
  parameter int unsigned LEVEL = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  v_i,
  input  wire srch_t d_i,
  output      logic  v_o,
  output      srch_t d_o
);

  localparam int unsigned BIT = IDX_W - 1 - LEVEL;

  logic              v_r;
  srch_t             d_r;
  srch_t             d_nxt;
  logic [IDX_W-1:0]  cand;
  logic [LHS_W-1:0]  prod;
  logic              hit;

  always_comb begin
    cand      = d_i.idx;
    cand[BIT] = 1'b1;
    prod      = LHS_W'(thr_at(cand)) * LHS_W'(d_i.baud);
    hit       = (cand < IDX_W'(TABLE_ENTRIES)) && (d_i.lhs > prod);
    d_nxt     = d_i;
    if (hit) begin
      d_nxt.idx = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

`default_nettype wire

// ===== src/uart_baud_divisor_calc.sv =====
// Pipeline from request accept to result valid: 32 divide cells, one
//   fraction-scale stage, 6 table-search cells, output register.
// Throughput: one transaction per cycle and one quotient bit per divide cell per cycle.
//   The one-entry skid keeps input open while a result waits and stalls it once full.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not reset.
`default_nettype none

module uart_baud_divisor_calc
  import ubd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ubd_in_if.sink    in_if,
  ubd_out_if.source out_if
);

  logic  en;
  logic  div_v [0:QUO_W];
  div_t  div_d [0:QUO_W];
  logic  srch_v [0:IDX_W];
  srch_t srch_d [0:IDX_W];

  logic  prep_v_r;
  srch_t prep_d_r;
  srch_t prep_nxt;

  logic  out_v_r, out_v_nxt;
  res_t  out_d_r, out_d_nxt;
  logic  skid_v_r, skid_v_nxt;
  res_t  skid_d_r, skid_d_nxt;
  res_t  res_c;
  logic  take;
  logic  tail_v;
  srch_t tail_d;

  assign en          = !skid_v_r;
  assign in_if.ready = en;

  assign div_v[0]      = in_if.valid;
  assign div_d[0].rem  = '0;
  assign div_d[0].num  = in_if.clock_hz;
  assign div_d[0].baud = in_if.baud_rate;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    ubd_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .v_i  (div_v[i]),
      .d_i  (div_d[i]),
      .v_o  (div_v[i+1]),
      .d_o  (div_d[i+1])
    );
  end

  // quotient/remainder -> error flag and scaled remainder
  always_comb begin
    prep_nxt.lhs    = LHS_W'({{THR_W{1'b0}}, div_d[QUO_W].rem} * {{BAUD_W{1'b0}}, FRAC_SCALE});
    prep_nxt.baud   = div_d[QUO_W].baud;
    prep_nxt.idx    = '0;
    prep_nxt.quo_lo = div_d[QUO_W].num[QLO_W-1:0];
    prep_nxt.err    = (div_d[QUO_W].baud == '0) || (|div_d[QUO_W].num[QUO_W-1:QLO_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (en) begin
      prep_v_r <= div_v[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_d_r <= prep_nxt;
    end
  end

  assign srch_v[0] = prep_v_r;
  assign srch_d[0] = prep_d_r;

  for (genvar j = 0; j < IDX_W; j++) begin : g_srch
    ubd_srch_cell #(.LEVEL(j)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .v_i  (srch_v[j]),
      .d_i  (srch_d[j]),
      .v_o  (srch_v[j+1]),
      .d_o  (srch_d[j+1])
    );
  end

  assign tail_v = srch_v[IDX_W];
  assign tail_d = srch_d[IDX_W];

  always_comb begin
    res_c.status     = tail_d.err;
    res_c.divisor    = tail_d.err ? '0 : tail_d.quo_lo[QLO_W-1:FMOD_W];
    res_c.first_mod  = tail_d.err ? '0 : tail_d.quo_lo[FMOD_W-1:0];
    res_c.second_mod = tail_d.err ? '0 : pat_at(tail_d.idx);
  end

  always_comb begin
    take       = out_v_r && out_if.ready;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (tail_v) begin
      if (!out_v_r || take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res_c;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = res_c;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_if.valid      = out_v_r;
  assign out_if.divisor    = out_d_r.divisor;
  assign out_if.first_mod  = out_d_r.first_mod;
  assign out_if.second_mod = out_d_r.second_mod;
  assign out_if.status     = out_d_r.status;

endmodule

`default_nettype wire

// ===== src/ubd_checker.sv =====
// Port-level checker for uart_baud_divisor_calc, attached by bind.
// Depends on ubd_pkg widths and the channel interfaces of the top level.
`default_nettype none

module ubd_sva
  import ubd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DIV_W-1:0]  divisor,
  input wire logic [FMOD_W-1:0] first_mod,
  input wire logic [SMOD_W-1:0] second_mod,
  input wire logic              status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> divisor == '0 && first_mod == '0 && second_mod == '0)
    else $error("error result with nonzero fields");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule

bind uart_baud_divisor_calc ubd_sva u_ubd_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .divisor   (out_if.divisor),
  .first_mod (out_if.first_mod),
  .second_mod(out_if.second_mod),
  .status    (out_if.status)
);

`default_nettype wire

// ===== dv/ubd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UART baud divisor calculator: watches both channels, predicts
// each result from the accepted request and compares field by field. Uses ubd_pkg, ubd_if.

module ubd_checker
  import ubd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ubd_in_if           in_mon,
  ubd_out_if          out_mon,
  output int unsigned fail_cnt,
  output int unsigned pend_cnt,
  output int unsigned res_cnt,
  output int unsigned err_cnt
);

  // fraction thresholds (1/10000) and the modulation pattern each selects
  localparam int unsigned FRAC_THR [TABLE_ENTRIES] = '{
       0,  529,  715,  835, 1001, 1252, 1430, 1670,
    2147, 2224, 2503, 3000, 3335, 3575, 3753, 4003,
    4286, 4378, 5002, 5715, 6003, 6254, 6432, 6667,
    7001, 7147, 7503, 7861, 8004, 8333, 8464, 8572,
    8751, 9004, 9170, 9288
  };

  localparam logic [SMOD_W-1:0] FRAC_PAT [TABLE_ENTRIES] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h11,
    8'h21, 8'h22, 8'h44, 8'h25, 8'h49, 8'h4A, 8'h52, 8'h92,
    8'h53, 8'h55, 8'hAA, 8'h6B, 8'hAD, 8'hB5, 8'hB6, 8'hD6,
    8'hB7, 8'hBB, 8'hDD, 8'hED, 8'hEE, 8'hBF, 8'hDF, 8'hEF,
    8'hF7, 8'hFB, 8'hFD, 8'hFE
  };

  res_t baud_settings_q[$];

  function automatic res_t calc_baud_settings(input logic [CLK_W-1:0] clk_hz,
                                              input logic [BAUD_W-1:0] baud);
    res_t        r;
    logic [63:0] c64;
    logic [63:0] b64;
    logic [63:0] quo;
    logic [63:0] lhs;
    r        = '0;
    r.status = 1'b1;
    c64      = 64'(clk_hz);
    b64      = 64'(baud);
    if (baud == '0) begin
      return r;
    end
    quo = c64 / (b64 << 4);
    if (quo > 64'd65535) begin
      return r;
    end
    r.divisor   = quo[DIV_W-1:0];
    r.first_mod = FMOD_W'((c64 % (b64 << 4)) / b64);
    lhs         = (c64 % b64) * 64'd10000;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (lhs > 64'(FRAC_THR[i]) * b64) begin
        r.second_mod = FRAC_PAT[i];
      end
    end
    r.status = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      fail_cnt = 0;
      pend_cnt = 0;
      res_cnt  = 0;
      err_cnt  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        baud_settings_q.push_back(calc_baud_settings(in_mon.clock_hz, in_mon.baud_rate));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.divisor    = out_mon.divisor;
        got.first_mod  = out_mon.first_mod;
        got.second_mod = out_mon.second_mod;
        got.status     = out_mon.status;
        res_cnt++;
        if (got.status) begin
          err_cnt++;
        end
        if (baud_settings_q.size() == 0) begin
          $display("%0t: result transaction with none pending: %h", $time, got);
          fail_cnt++;
        end else begin
          want = baud_settings_q.pop_front();
          if (got.divisor !== want.divisor) begin
            $display("%0t: divisor expected %h actual %h", $time, want.divisor, got.divisor);
            fail_cnt++;
          end
          if (got.first_mod !== want.first_mod) begin
            $display("%0t: first_mod expected %h actual %h", $time,
                     want.first_mod, got.first_mod);
            fail_cnt++;
          end
          if (got.second_mod !== want.second_mod) begin
            $display("%0t: second_mod expected %h actual %h", $time,
                     want.second_mod, got.second_mod);
            fail_cnt++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %h actual %h", $time, want.status, got.status);
            fail_cnt++;
          end
        end
      end
      pend_cnt = baud_settings_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for uart_baud_divisor_calc: drives directed and random requests under
// several handshake idle mixes and gives the verdict. Uses ubd_pkg, ubd_if, ubd_checker.

module tb_top;
  import ubd_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 208;
  localparam int unsigned DRAIN_CYCLES    = 60;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned fail_cnt;
  int unsigned pend_cnt;
  int unsigned res_cnt;
  int unsigned err_cnt;

  ubd_in_if  in_if ();
  ubd_out_if out_if ();

  uart_baud_divisor_calc u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  ubd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .fail_cnt (fail_cnt),
    .pend_cnt (pend_cnt),
    .res_cnt  (res_cnt),
    .err_cnt  (err_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [CLK_W-1:0] c, input logic [BAUD_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.clock_hz  <= c;
    in_if.baud_rate <= b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic send_frac(input logic [BAUD_W-1:0] b, input int unsigned d,
                           input int unsigned r);
    send_req(CLK_W'(64'(d) * 64'(b) * 64'd16 + 64'(r)), b);
  endtask

  task automatic gen_req(output logic [CLK_W-1:0] c, output logic [BAUD_W-1:0] b);
    int unsigned kind;
    int unsigned k;
    int unsigned dmax;
    logic [63:0] lo;
    logic [63:0] c64;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      c = $urandom;
      b = BAUD_W'($urandom);
    end else if (kind < 20) begin
      c = $urandom;
      b = '0;
    end else if (kind < 25) begin
      b   = BAUD_W'($urandom_range(1, 4095));
      lo  = 64'(b) << 20;
      c64 = lo + (64'($urandom) % (64'h1_0000_0000 - lo));
      c   = c64[CLK_W-1:0];
    end else begin
      k = $urandom_range(1, BAUD_W);
      b = BAUD_W'($urandom) & BAUD_W'((32'd1 << k) - 1);
      if (b == '0) begin
        b = BAUD_W'(1);
      end
      dmax = 32'hFFFF_FFFF / (32'(b) * 16);
      if (dmax > 65535) begin
        dmax = 65535;
      end
      c64 = 64'($urandom_range(0, dmax)) * 64'(b) * 64'd16
          + (64'($urandom) % (64'(b) * 64'd16));
      if (c64 > 64'hFFFF_FFFF) begin
        c64 = 64'hFFFF_FFFF;
      end
      if ($urandom_range(0, 9) == 0) begin
        c64 = c64 - (c64 % 64'(b));
      end
      c = c64[CLK_W-1:0];
    end
  endtask

  initial begin
    logic [CLK_W-1:0]  c;
    logic [BAUD_W-1:0] b;
    in_if.valid     = 1'b0;
    in_if.clock_hz  = '0;
    in_if.baud_rate = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // edges of the ranges, error cases and table boundaries
    send_req(32'd0, 24'd0);
    send_req(32'hFFFF_FFFF, 24'd0);
    send_req(32'd0, 24'd1);
    send_req(32'd1, 24'd1);
    send_req(32'hFFFF_FFFF, 24'd1);
    send_req(32'hFFFF_FFFF, 24'hFF_FFFF);
    send_req(32'hFF_FFFE, 24'hFF_FFFF);
    send_req(32'h000F_FFF0, 24'd1);
    send_req(32'h000F_FFFF, 24'd1);
    send_req(32'h0010_0000, 24'd1);
    send_req(32'h8000_0000, 24'h80_0000);
    send_req(32'd153599, 24'd9600);
    send_req(32'd960000, 24'd9600);
    send_req(32'd8000000, 24'd9600);
    send_req(32'd16000000, 24'd115200);
    send_req(32'd48000000, 24'd3000000);
    send_frac(24'd10000, 5, 529);
    send_frac(24'd10000, 5, 530);
    send_frac(24'd10000, 7, 5002);
    send_frac(24'd10000, 7, 5003);
    send_frac(24'd10000, 3, 9288);
    send_frac(24'd10000, 3, 9289);
    send_frac(24'd10000, 3, 9999);
    send_frac(24'd10000, 65535, 159999);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 69;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 69;
        end
        default: begin
          src_idle_pct  = 24;
          snk_stall_pct = 24;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_if.valid <= 1'b0;
          @(negedge clk);
          while (pend_cnt != 0) @(negedge clk);
        end
        gen_req(c, b);
        send_req(c, b);
      end
    end
    in_if.valid <= 1'b0;

    while (pend_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d result transactions (%0d error status) over directed edges",
             res_cnt, err_cnt);
    $display("and random requests under four source/sink idle mixes with one full drain.");
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
